// ===== hw/rtl/dsts_pkg.sv =====
package dsts_pkg;

	// fixed field widths on the ports
	localparam int unsigned FIELD_W     = 7;
	localparam int unsigned TASK_NUM_W  = 4;
	localparam int unsigned S_TDATA_W   = 16;
	localparam int unsigned M_TDATA_W   = 8;

	typedef struct packed {
		logic load;        // store the accepted word as a task
		logic set_start;   // last word of the set taken: reset loop state
		logic clr_step;    // clear one slot of the slot map
		logic sel_start;   // begin a selection scan
		logic sel_step;    // advance the selection scan
		logic sel_take;    // retire the chosen task and start its walk
		logic walk_step;   // advance the slot walk
		logic mark_start;  // latch the run to be occupied
		logic mark_step;   // occupy one slot
		logic emit;        // move pending result out, hold the new one
		logic flush;       // send the closing result of the run
	} cmd_t;

	typedef struct packed {
		logic clr_last;
		logic iter_end;
		logic sel_done;
		logic hit;
		logic fail;
		logic dur_zero;
		logic mark_last;
		logic pend_vld;
		logic out_free;
	} stat_t;

endpackage

// ===== hw/rtl/dsts_ctrl.sv =====
module dsts_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            s_tvalid,
	input  logic            s_tlast,
	output logic            s_tready,
	input  dsts_pkg::stat_t stat,
	output dsts_pkg::cmd_t  cmd
);
	import dsts_pkg::*;

	localparam logic [2:0] ST_LOAD  = 3'd0;
	localparam logic [2:0] ST_CLEAR = 3'd1;
	localparam logic [2:0] ST_NEXT  = 3'd2;
	localparam logic [2:0] ST_SEL   = 3'd3;
	localparam logic [2:0] ST_WALK  = 3'd4;
	localparam logic [2:0] ST_MARK  = 3'd5;
	localparam logic [2:0] ST_EMIT  = 3'd6;
	localparam logic [2:0] ST_FLUSH = 3'd7;

	logic [2:0] state_q;
	logic [2:0] state_d;

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		s_tready = 1'b0;
		case (state_q)
			ST_LOAD: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.load = 1'b1;
					if (s_tlast) begin
						cmd.set_start = 1'b1;
						state_d       = ST_CLEAR;
					end
				end
			end
			ST_CLEAR: begin
				cmd.clr_step = 1'b1;
				if (stat.clr_last) begin
					state_d = ST_NEXT;
				end
			end
			ST_NEXT: begin
				if (stat.iter_end) begin
					state_d = ST_FLUSH;
				end else begin
					cmd.sel_start = 1'b1;
					state_d       = ST_SEL;
				end
			end
			ST_SEL: begin
				cmd.sel_step = 1'b1;
				if (stat.sel_done) begin
					cmd.sel_take = 1'b1;
					state_d      = ST_WALK;
				end
			end
			ST_WALK: begin
				cmd.walk_step = 1'b1;
				if (stat.hit) begin
					cmd.mark_start = 1'b1;
					state_d        = stat.dur_zero ? ST_EMIT : ST_MARK;
				end else if (stat.fail) begin
					state_d = ST_NEXT;
				end
			end
			ST_MARK: begin
				cmd.mark_step = 1'b1;
				if (stat.mark_last) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				// wait for the output register only when a word has to move out
				if (!stat.pend_vld || stat.out_free) begin
					cmd.emit = 1'b1;
					state_d  = ST_NEXT;
				end
			end
			ST_FLUSH: begin
				if (stat.out_free) begin
					cmd.flush = 1'b1;
					state_d   = ST_LOAD;
				end
			end
			default: begin
				state_d = ST_LOAD;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ===== hw/rtl/dsts_dpath.sv =====
module dsts_dpath #(
	parameter int unsigned MAX_TASKS = 16,
	parameter int unsigned MAX_SLOTS = 64
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic [dsts_pkg::S_TDATA_W-1:0]      s_tdata,
	input  dsts_pkg::cmd_t                      cmd,
	output dsts_pkg::stat_t                     stat,
	input  logic                                m_tready,
	output logic                                m_tvalid,
	output logic [dsts_pkg::M_TDATA_W-1:0]      m_tdata,
	output logic                                m_tuser,
	output logic                                m_tlast
);
	import dsts_pkg::*;

	// slot values 0..MAX_SLOTS, slot map addressed by slot - 1
	localparam int unsigned SW   = $clog2(MAX_SLOTS + 1);
	localparam int unsigned CW   = (SW > FIELD_W) ? SW : FIELD_W;
	localparam int unsigned AW   = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
	localparam int unsigned CNTW = $clog2(MAX_TASKS + 1);
	localparam int unsigned TAW  = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
	localparam int unsigned IXW  = (TAW > TASK_NUM_W) ? TAW : TASK_NUM_W;
	localparam int unsigned KW   = 2 * SW;

	// task store: {duration, deadline}
	logic [KW-1:0]  task_mem [MAX_TASKS];
	logic [KW-1:0]  task_rd_s1;
	logic           slot_mem [MAX_SLOTS];
	logic           slot_rd_s1;

	logic [CNTW-1:0] cnt_q;
	logic [CNTW-1:0] iter_q;
	logic [CNTW-1:0] scan_q;
	logic [MAX_TASKS-1:0] done_q;
	logic [AW-1:0]   clr_q;

	logic            srv_s1;
	logic [TAW-1:0]  sidx_s1;
	logic            best_vld_q;
	logic [KW-1:0]   best_q;
	logic [TAW-1:0]  best_idx_q;

	logic [SW-1:0]   iss_q;
	logic            wrv_s1;
	logic [SW-1:0]   wslot_s1;
	logic [SW-1:0]   run_q;
	logic [SW-1:0]   run_inc;
	logic [SW-1:0]   mk_q;
	logic [SW-1:0]   mcnt_q;

	logic            pend_vld_q;
	logic [TAW-1:0]  pend_idx_q;
	logic            out_vld_q;
	logic [TASK_NUM_W-1:0] out_num_q;
	logic            out_none_q;
	logic            out_last_q;

	logic [CW-1:0]   in_dur_ext;
	logic [CW-1:0]   in_dl_ext;
	logic [SW-1:0]   in_dur;
	logic [SW-1:0]   in_dl;
	logic [SW-1:0]   best_dur;
	logic [SW-1:0]   best_dl;
	logic            cand_better;
	logic            free_slot;
	logic            out_free;
	logic [IXW-1:0]  pend_ext;

	// saturate incoming fields at the slot count
	assign in_dur_ext = CW'(s_tdata[FIELD_W-1:0]);
	assign in_dl_ext  = CW'(s_tdata[2*FIELD_W-1:FIELD_W]);
	assign in_dur = (in_dur_ext > CW'(MAX_SLOTS)) ? SW'(MAX_SLOTS) : SW'(in_dur_ext);
	assign in_dl  = (in_dl_ext  > CW'(MAX_SLOTS)) ? SW'(MAX_SLOTS) : SW'(in_dl_ext);

	assign best_dur = best_q[KW-1:SW];
	assign best_dl  = best_q[SW-1:0];

	// ties on duration and deadline keep the earlier index: scan runs upwards
	assign cand_better = srv_s1 && !done_q[sidx_s1] &&
	                     (!best_vld_q || (task_rd_s1 < best_q));

	assign free_slot = wrv_s1 && !slot_rd_s1;
	assign run_inc   = run_q + SW'(1);
	assign out_free  = !out_vld_q || m_tready;
	assign pend_ext  = IXW'(pend_idx_q);

	always_comb begin
		stat           = '0;
		stat.clr_last  = (clr_q == AW'(MAX_SLOTS - 1));
		stat.iter_end  = (iter_q == cnt_q);
		stat.sel_done  = (scan_q == cnt_q) && !srv_s1;
		stat.hit       = free_slot && ((best_dur == '0) || (run_inc >= best_dur));
		stat.fail      = !wrv_s1 && (iss_q == '0);
		stat.dur_zero  = (best_dur == '0);
		stat.mark_last = (mcnt_q == SW'(1));
		stat.pend_vld  = pend_vld_q;
		stat.out_free  = out_free;
	end

	// memories
	always_ff @(posedge clk) begin
		if (cmd.load && (cnt_q < CNTW'(MAX_TASKS))) begin
			task_mem[cnt_q[TAW-1:0]] <= {in_dur, in_dl};
		end
		task_rd_s1 <= task_mem[scan_q[TAW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (cmd.clr_step) begin
			slot_mem[clr_q] <= 1'b0;
		end else if (cmd.mark_step) begin
			slot_mem[AW'(mk_q - SW'(1))] <= 1'b1;
		end
		slot_rd_s1 <= slot_mem[AW'(iss_q - SW'(1))];
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.sel_step && srv_s1 == 1'b0 && scan_q != cnt_q) begin
			sidx_s1 <= scan_q[TAW-1:0];
		end else if (cmd.sel_step) begin
			sidx_s1 <= scan_q[TAW-1:0];
		end
		if (cand_better && cmd.sel_step) begin
			best_q     <= task_rd_s1;
			best_idx_q <= sidx_s1;
		end
		if (cmd.walk_step && iss_q != '0) begin
			wslot_s1 <= iss_q;
		end
		if (cmd.mark_start) begin
			mk_q <= wslot_s1;
		end else if (cmd.mark_step) begin
			mk_q <= mk_q + SW'(1);
		end
		if (cmd.emit) begin
			pend_idx_q <= best_idx_q;
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q      <= '0;
			iter_q     <= '0;
			scan_q     <= '0;
			done_q     <= '0;
			clr_q      <= '0;
			srv_s1     <= 1'b0;
			best_vld_q <= 1'b0;
			iss_q      <= '0;
			wrv_s1     <= 1'b0;
			run_q      <= '0;
			mcnt_q     <= '0;
			pend_vld_q <= 1'b0;
			out_vld_q  <= 1'b0;
			out_num_q  <= '0;
			out_none_q <= 1'b0;
			out_last_q <= 1'b0;
		end else begin
			// drop excess tasks once the store is full
			if (cmd.flush) begin
				cnt_q <= '0;
			end else if (cmd.load && (cnt_q < CNTW'(MAX_TASKS))) begin
				cnt_q <= cnt_q + CNTW'(1);
			end

			if (cmd.set_start) begin
				iter_q <= '0;
				done_q <= '0;
				clr_q  <= '0;
			end else begin
				if (cmd.clr_step) begin
					clr_q <= clr_q + AW'(1);
				end
				if (cmd.sel_take) begin
					iter_q              <= iter_q + CNTW'(1);
					done_q[best_idx_q]  <= 1'b1;
				end
			end

			if (cmd.sel_start) begin
				scan_q     <= '0;
				srv_s1     <= 1'b0;
				best_vld_q <= 1'b0;
			end else if (cmd.sel_step) begin
				srv_s1 <= (scan_q != cnt_q);
				if (scan_q != cnt_q) begin
					scan_q <= scan_q + CNTW'(1);
				end
				if (cand_better) begin
					best_vld_q <= 1'b1;
				end
			end

			// walk the slot map downwards from the deadline
			if (cmd.sel_take) begin
				iss_q  <= best_dl;
				wrv_s1 <= 1'b0;
				run_q  <= '0;
			end else if (cmd.walk_step) begin
				wrv_s1 <= (iss_q != '0);
				if (iss_q != '0) begin
					iss_q <= iss_q - SW'(1);
				end
				if (wrv_s1) begin
					run_q <= slot_rd_s1 ? '0 : run_inc;
				end
			end

			if (cmd.mark_start) begin
				mcnt_q <= best_dur;
			end else if (cmd.mark_step) begin
				mcnt_q <= mcnt_q - SW'(1);
			end

			// hold one result back so the closing word can carry tlast
			if (cmd.emit) begin
				pend_vld_q <= 1'b1;
			end else if (cmd.flush) begin
				pend_vld_q <= 1'b0;
			end

			if ((cmd.emit && pend_vld_q) || cmd.flush) begin
				out_vld_q  <= 1'b1;
				out_num_q  <= pend_vld_q ? pend_ext[TASK_NUM_W-1:0] : '0;
				out_none_q <= cmd.flush && !pend_vld_q;
				out_last_q <= cmd.flush;
			end else if (m_tready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = M_TDATA_W'(out_num_q);
	assign m_tuser  = out_none_q;
	assign m_tlast  = out_last_q;

endmodule

// ===== hw/rtl/deadline_slot_task_selector.sv =====
// Loading: one task word per cycle, no result.
// Scheduling after the tlast word: the slot map is cleared slot by slot, then per task a
// selection scan over the task store and a slot walk down from its deadline; if the walk
// finds room, slots are occupied one by one (one slot map port) and it is handed over.
// Results leave through an output register; one word per set carries tlast.
// arst_n clears all control state; the slot map is cleared at the start of every set.
module deadline_slot_task_selector #(
	parameter int unsigned MAX_TASKS = 16,
	parameter int unsigned MAX_SLOTS = 64
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [dsts_pkg::S_TDATA_W-1:0]  s_tdata,  // duration[6:0], deadline[13:7]
	input  logic                            s_tlast,  // final_task
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [dsts_pkg::M_TDATA_W-1:0]  m_tdata,  // task_number[3:0]
	output logic                            m_tuser,  // none_chosen
	output logic                            m_tlast   // end_of_list
);
	import dsts_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	dsts_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tlast  (s_tlast),
		.s_tready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	dsts_dpath #(
		.MAX_TASKS (MAX_TASKS),
		.MAX_SLOTS (MAX_SLOTS)
	) u_dpath (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tdata  (s_tdata),
		.cmd      (cmd),
		.stat     (stat),
		.m_tready (m_tready),
		.m_tvalid (m_tvalid),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule
